// ----- hdl/assert_macros.svh -----
// Assertion shorthands used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds at the same edge
`define LMSC_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// ante holds -> cons holds at the next edge
`define LMSC_ASSERT_NXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define LMSC_ASSERT_IMP(name, clk_s, rstn_s, ante, cons)
`define LMSC_ASSERT_NXT(name, clk_s, rstn_s, ante, cons)

`endif

`endif

// ----- hdl/lmsc_pkg.sv -----
package lmsc_pkg;

    // Buffer limits
    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // Field widths
    localparam int PIX_W      = 16;
    localparam int CNT_W      = 16;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    // Register reset values
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 11'd6;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 6'd8;

    typedef logic signed [PIX_W-1:0] pix_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic lag_latch;    // center value on read port, fetch right neighbor
        logic lag_emit;     // decide, write back, load lag result
        logic flush_read;   // fetch next element of the last row
        logic flush_emit;   // load flush result
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic r_zero;       // next input lands in the first row
        logic final_now;    // next input is the last of the image
        logic final_item;   // item in progress is the last of the image
        logic flush_last;   // flush index is on the last column
        logic out_free;     // output register can take a result
    } sts_t;

endpackage

// ----- hdl/lmsc_ifs.sv -----
// Input pixel stream
interface lmsc_pix_if;
    import lmsc_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

// Result stream
interface lmsc_res_if;
    import lmsc_pkg::*;
    logic             valid;
    logic             ready;
    pix_t             pixel_out;
    logic             was_minimum;
    logic [CNT_W-1:0] minima_count;
    logic             image_done;
    logic             last;
    modport source (output valid, output pixel_out, output was_minimum,
                    output minima_count, output image_done, output last, input ready);
    modport sink (input valid, input pixel_out, input was_minimum,
                  input minima_count, input image_done, input last, output ready);
endinterface

// Register write channel
interface lmsc_cfg_if;
    import lmsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- hdl/local_minimum_suppress_count_core.sv -----
// First-row input: no result; the sequencer stays ready for the next transfer.
// Later input: lag read, then lag emit, which waits for a free output register and loads the lag result.
// Final input adds the last-row flush: a flush read and a flush load per element (one RAM read each).
// Result register frees the input side while a result waits on the output.
// Reset (async, active low): 6 rows, 8 columns, position and count zero;
// row buffers hold no reset value and need no clearing pass.
`include "assert_macros.svh"

module local_minimum_suppress_count_core (
    input  logic        clk,
    input  logic        rst_n,
    lmsc_pix_if.sink    src,
    lmsc_res_if.source  dst,
    lmsc_cfg_if.sink    cfg
);
    import lmsc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic flush_end;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    lmsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (src.valid),
        .in_ready (src.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lmsc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .pixel_in     (src.pixel_in),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.reg_index),
        .cfg_data     (cfg.reg_data),
        .out_valid    (dst.valid),
        .out_ready    (dst.ready),
        .pixel_out    (dst.pixel_out),
        .was_minimum  (dst.was_minimum),
        .minima_count (dst.minima_count),
        .image_done   (dst.image_done),
        .last         (dst.last)
    );

    // Last flush load of the image
    assign flush_end = cmd.flush_emit && sts.flush_last;

    // A suppressed element reads as zero and has been counted
    `LMSC_ASSERT_IMP(a_min_zero, clk, rst_n, dst.valid && dst.was_minimum, dst.pixel_out == '0)
    `LMSC_ASSERT_IMP(a_min_counted, clk, rst_n, dst.valid && dst.was_minimum, dst.minima_count != 0)
    // End of image closes the item's results
    `LMSC_ASSERT_IMP(a_done_last, clk, rst_n, dst.valid && dst.image_done, dst.last)
    // Last flush load shows up as the end-of-image result
    `LMSC_ASSERT_NXT(a_flush_end, clk, rst_n, flush_end, dst.valid && dst.image_done && dst.last)

endmodule

// ----- hdl/lmsc_ram.sv -----
// Simple dual-port RAM, one write port, one registered read port
module lmsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/lmsc_ctrl.sv -----
// Sequencer: one item at a time, lag result below the first row, then optional last-row flush
module lmsc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lmsc_pkg::sts_t sts,
    output lmsc_pkg::cmd_t cmd
);
    import lmsc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAG_RD = 3'd1;
    localparam logic [2:0] S_LAG_EM = 3'd2;
    localparam logic [2:0] S_FL_RD  = 3'd3;
    localparam logic [2:0] S_FL_EM  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.r_zero)
                    begin
                        state_next = S_LAG_RD;
                    end
                    else if (sts.final_now)
                    begin
                        state_next = S_FL_RD;
                    end
                end
            end
            S_LAG_RD:
            begin
                cmd.lag_latch = 1'b1;
                state_next    = S_LAG_EM;
            end
            S_LAG_EM:
            begin
                if (sts.out_free)
                begin
                    cmd.lag_emit = 1'b1;
                    state_next   = sts.final_item ? S_FL_RD : S_IDLE;
                end
            end
            S_FL_RD:
            begin
                cmd.flush_read = 1'b1;
                state_next     = S_FL_EM;
            end
            S_FL_EM:
            begin
                if (sts.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    state_next     = sts.flush_last ? S_IDLE : S_FL_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/lmsc_datapath.sv -----
// Row buffers, position counters, neighbor compare and result register
module lmsc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lmsc_pkg::cmd_t                  cmd,
    output lmsc_pkg::sts_t                  sts,
    input  lmsc_pkg::pix_t                  pixel_in,
    input  logic                            cfg_valid,
    input  logic [lmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lmsc_pkg::pix_t                  pixel_out,
    output logic                            was_minimum,
    output logic [lmsc_pkg::CNT_W-1:0]      minima_count,
    output logic                            image_done,
    output logic                            last
);
    import lmsc_pkg::*;

    // Configuration and position state
    logic [ROWS_CFG_W-1:0] row_count_reg, row_count_next;
    logic [COLS_CFG_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0]      row_pos_reg, row_pos_next;
    logic [COL_W-1:0]      col_pos_reg, col_pos_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [COL_W-1:0]      flush_idx_reg, flush_idx_next;

    // Item in progress
    pix_t                  px_reg, px_next;
    pix_t                  cur_reg, cur_next;
    pix_t                  left_reg, left_next;
    logic [COL_W-1:0]      cur_c_reg, cur_c_next;
    logic                  r_ge2_reg, r_ge2_next;
    logic                  final_reg, final_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    pix_t                  out_pix_reg, out_pix_next;
    logic                  out_min_reg, out_min_next;
    logic [CNT_W-1:0]      out_cnt_reg, out_cnt_next;
    logic                  out_done_reg, out_done_next;
    logic                  out_last_reg, out_last_next;

    // RAM ports
    logic                  pend_wr_en, pend_rd_en, fin_wr_en, fin_rd_en;
    logic [COL_W-1:0]      pend_wr_addr, pend_rd_addr;
    pix_t                  pend_wr_data, pend_rd_data, fin_rd_data;

    // Derived terms
    logic                  col_wrap;
    logic                  final_now;
    logic                  interior;
    logic                  is_min;
    pix_t                  lag_v;
    logic [CNT_W-1:0]      lag_cnt;
    logic                  flush_last;
    logic                  out_free;
    logic [ROWS_CFG_W-1:0] rows_sat;
    logic [COLS_CFG_W-1:0] cols_sat;

    // Row buffers
    lmsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_pend_ram (
        .clk     (clk),
        .wr_en   (pend_wr_en),
        .wr_addr (pend_wr_addr),
        .wr_data (pend_wr_data),
        .rd_en   (pend_rd_en),
        .rd_addr (pend_rd_addr),
        .rd_data (pend_rd_data)
    );

    lmsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_fin_ram (
        .clk     (clk),
        .wr_en   (fin_wr_en),
        .wr_addr (cur_c_reg),
        .wr_data (lag_v),
        .rd_en   (fin_rd_en),
        .rd_addr (col_pos_reg),
        .rd_data (fin_rd_data)
    );

    // Position decode
    assign col_wrap   = (COLS_CFG_W'(col_pos_reg) + COLS_CFG_W'(1)) == col_count_reg;
    assign final_now  = col_wrap &&
                        ((ROWS_CFG_W'(row_pos_reg) + ROWS_CFG_W'(1)) == row_count_reg);
    assign flush_last = (COLS_CFG_W'(flush_idx_reg) + COLS_CFG_W'(1)) == col_count_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Strict minimum against top, left (final values) and bottom, right (originals)
    assign interior = r_ge2_reg && (cur_c_reg != '0) &&
                      ((COLS_CFG_W'(cur_c_reg) + COLS_CFG_W'(1)) < col_count_reg);
    assign is_min   = interior && (cur_reg < fin_rd_data) && (cur_reg < left_reg) &&
                      (cur_reg < px_reg) && (cur_reg < pend_rd_data);
    assign lag_v    = is_min ? pix_t'(0) : cur_reg;
    assign lag_cnt  = (is_min && (count_reg != '1)) ? count_reg + CNT_W'(1) : count_reg;

    // Buffer access
    assign pend_wr_en   = (cmd.accept && sts.r_zero) || cmd.lag_emit;
    assign pend_wr_addr = cmd.lag_emit ? cur_c_reg : col_pos_reg;
    assign pend_wr_data = cmd.lag_emit ? px_reg : pixel_in;
    assign pend_rd_en   = (cmd.accept && !sts.r_zero) || cmd.lag_latch || cmd.flush_read;
    assign fin_wr_en    = cmd.lag_emit;
    assign fin_rd_en    = cmd.accept && !sts.r_zero;

    always_comb
    begin
        if (cmd.lag_latch)
        begin
            pend_rd_addr = cur_c_reg + COL_W'(1);
        end
        else if (cmd.flush_read)
        begin
            pend_rd_addr = flush_idx_reg;
        end
        else
        begin
            pend_rd_addr = col_pos_reg;
        end
    end

    // Register write values, zero taken as one, saturated at the buffer limits
    always_comb
    begin
        rows_sat = cfg_data[ROWS_CFG_W-1:0];
        if (rows_sat == '0)
        begin
            rows_sat = ROWS_CFG_W'(1);
        end
        else if (rows_sat > ROWS_CFG_W'(MAX_ROWS))
        begin
            rows_sat = ROWS_CFG_W'(MAX_ROWS);
        end
        cols_sat = cfg_data[COLS_CFG_W-1:0];
        if (cols_sat == '0)
        begin
            cols_sat = COLS_CFG_W'(1);
        end
        else if (cols_sat > COLS_CFG_W'(MAX_COLS))
        begin
            cols_sat = COLS_CFG_W'(MAX_COLS);
        end
    end

    // Next state
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        count_next     = count_reg;
        flush_idx_next = flush_idx_reg;
        px_next        = px_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        cur_c_next     = cur_c_reg;
        r_ge2_next     = r_ge2_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pix_next   = out_pix_reg;
        out_min_next   = out_min_reg;
        out_cnt_next   = out_cnt_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;

        // Input transfer: capture item, step raster position
        if (cmd.accept)
        begin
            px_next    = pixel_in;
            cur_c_next = col_pos_reg;
            r_ge2_next = row_pos_reg >= ROW_W'(2);
            final_next = final_now;
            if (final_now)
            begin
                row_pos_next = '0;
                col_pos_next = '0;
            end
            else if (col_wrap)
            begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end

        if (cmd.lag_latch)
        begin
            cur_next = pend_rd_data;
        end

        // Lag result: element one row above the input
        if (cmd.lag_emit)
        begin
            left_next      = lag_v;
            count_next     = lag_cnt;
            out_valid_next = 1'b1;
            out_pix_next   = lag_v;
            out_min_next   = is_min;
            out_cnt_next   = lag_cnt;
            out_done_next  = 1'b0;
            out_last_next  = !final_reg;
        end

        // Last row flush
        if (cmd.flush_emit)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = pend_rd_data;
            out_min_next   = 1'b0;
            out_cnt_next   = count_reg;
            out_done_next  = flush_last;
            out_last_next  = flush_last;
            if (flush_last)
            begin
                flush_idx_next = '0;
                count_next     = '0;
            end
            else
            begin
                flush_idx_next = flush_idx_reg + COL_W'(1);
            end
        end

        // Register write abandons the image
        if (cfg_valid)
        begin
            if (cfg_index == REG_ROW_COUNT)
            begin
                row_count_next = rows_sat;
            end
            else if (cfg_index == REG_COL_COUNT)
            begin
                col_count_next = cols_sat;
            end
            row_pos_next   = '0;
            col_pos_next   = '0;
            count_next     = '0;
            flush_idx_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROWS_RESET;
            col_count_reg <= COLS_RESET;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            count_reg     <= '0;
            flush_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            count_reg     <= count_next;
            flush_idx_reg <= flush_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        cur_reg      <= cur_next;
        left_reg     <= left_next;
        cur_c_reg    <= cur_c_next;
        r_ge2_reg    <= r_ge2_next;
        final_reg    <= final_next;
        out_pix_reg  <= out_pix_next;
        out_min_reg  <= out_min_next;
        out_cnt_reg  <= out_cnt_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
    end

    // Status and outputs
    assign sts.r_zero     = row_pos_reg == '0;
    assign sts.final_now  = final_now;
    assign sts.final_item = final_reg;
    assign sts.flush_last = flush_last;
    assign sts.out_free   = out_free;

    assign out_valid    = out_valid_reg;
    assign pixel_out    = out_pix_reg;
    assign was_minimum  = out_min_reg;
    assign minima_count = out_cnt_reg;
    assign image_done   = out_done_reg;
    assign last         = out_last_reg;

endmodule

// ----- tb/minima_tracker_pkg.sv -----
`timescale 1ns / 100ps

package minima_tracker_pkg;
    import lmsc_pkg::*;

    // One finalized element as it should leave the block
    typedef struct {
        pix_t             pixel;
        logic             minimum;
        logic [CNT_W-1:0] count;
        logic             done;
        logic             last;
    } final_pixel_t;

    class minima_tracker;
        int unsigned  rows;
        int unsigned  cols;
        int unsigned  row_pos;
        int unsigned  col_pos;
        int unsigned  found;
        pix_t         open_row[MAX_COLS];
        pix_t         done_row[MAX_COLS];
        final_pixel_t finalized_q[$];

        int unsigned errors;
        int unsigned pixels;
        int unsigned results;
        int unsigned images;
        int unsigned minima;
        int unsigned writes;

        function new();
            rows = ROWS_RESET;
            cols = COLS_RESET;
            foreach (open_row[i])
            begin
                open_row[i] = '0;
                done_row[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            row_pos = 0;
            col_pos = 0;
            found   = 0;
        endfunction

        // Any register write clamps its value and drops the image in progress
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned v;
            writes++;
            if (idx == REG_ROW_COUNT)
                v = data;
            else
                v = data[COLS_CFG_W-1:0];
            if (v == 0)
                v = 1;
            if (idx == REG_ROW_COUNT)
                rows = (v > MAX_ROWS) ? MAX_ROWS : v;
            else
                cols = (v > MAX_COLS) ? MAX_COLS : v;
            restart();
        endfunction

        function void push_final(pix_t px, logic mn, logic done, logic lst);
            final_pixel_t e;
            e.pixel   = px;
            e.minimum = mn;
            e.count   = found[CNT_W-1:0];
            e.done    = done;
            e.last    = lst;
            finalized_q.push_back(e);
        endfunction

        // Accepted input: finalize the element above it, flush on the last one
        function void take_pixel(pix_t px);
            logic final_in;
            pix_t cur;
            pix_t v;
            logic mn;
            pixels++;
            final_in = (row_pos + 1 == rows) && (col_pos + 1 == cols);
            if (row_pos == 0)
            begin
                open_row[col_pos] = px;
            end
            else
            begin
                cur = open_row[col_pos];
                v   = cur;
                mn  = 1'b0;
                // interior: top/left already final, bottom/right still original
                if (row_pos >= 2 && col_pos >= 1 && col_pos + 1 < cols)
                begin
                    if (cur < done_row[col_pos] && cur < done_row[col_pos - 1] &&
                        cur < px && cur < open_row[col_pos + 1])
                    begin
                        v  = '0;
                        mn = 1'b1;
                        minima++;
                        if (found < 65535)
                            found++;
                    end
                end
                done_row[col_pos] = v;
                open_row[col_pos] = px;
                push_final(v, mn, 1'b0, !final_in);
            end
            if (final_in)
            begin
                for (int j = 0; j < cols; j++)
                    push_final(open_row[j], 1'b0, j == cols - 1, j == cols - 1);
                restart();
            end
            else
            begin
                col_pos++;
                if (col_pos == cols)
                begin
                    col_pos = 0;
                    row_pos++;
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_pixel_out(pix_t px, logic mn, logic [CNT_W-1:0] cnt, logic done, logic lst);
            final_pixel_t e;
            results++;
            if (finalized_q.size() == 0)
            begin
                report($sformatf("result with nothing due: pixel %0d", px));
                return;
            end
            e = finalized_q.pop_front();
            if (px !== e.pixel)
                report($sformatf("pixel_out %0d, want %0d", px, e.pixel));
            if (mn !== e.minimum)
                report($sformatf("was_minimum %b, want %b", mn, e.minimum));
            if (cnt !== e.count)
                report($sformatf("minima_count %0d, want %0d", cnt, e.count));
            if (done !== e.done)
                report($sformatf("image_done %b, want %b", done, e.done));
            if (lst !== e.last)
                report($sformatf("last %b, want %b", lst, e.last));
            if (e.done)
                images++;
        endtask

        function int outstanding();
            return finalized_q.size();
        endfunction
    endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import lmsc_pkg::*;
    import minima_tracker_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RANDOM_PIXELS = 40;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TALL_PIXELS   = 24;

    typedef enum int {FILL_WIDE, FILL_NARROW, FILL_CHECKER, FILL_EXTREME} fill_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lmsc_pix_if pix_ch();
    lmsc_res_if res_ch();
    lmsc_cfg_if cfg_ch();

    local_minimum_suppress_count_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (pix_ch),
        .dst   (res_ch),
        .cfg   (cfg_ch)
    );

    minima_tracker sb = new();

    bit          calm;
    bit          hold_req;
    int unsigned holds_done;
    int unsigned random_pixels;

    always #HALF_PERIOD clk = ~clk;

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: check every transfer
    always @(posedge clk)
    begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_pixel_out(res_ch.pixel_out, res_ch.was_minimum, res_ch.minima_count,
                               res_ch.image_done, res_ch.last);
    end

    // Result side: ready with random stalls, bursts of full rate, long hold-offs
    initial
    begin
        int unsigned pct;
        int unsigned pick;
        res_ch.ready = 1'b0;
        holds_done   = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    res_ch.ready <= 1'b0;
                    repeat ($urandom_range(15, 60)) @(posedge clk);
                end
                else
                begin
                    pct = (pick < 40) ? 0 : (pick < 80) ? 25 : 60;
                    repeat ($urandom_range(1, 40))
                    begin
                        res_ch.ready <= ($urandom_range(0, 99) >= pct);
                        @(posedge clk);
                    end
                end
            end
        end
    end

    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function pix_t make_pixel(fill_t fill, int unsigned r, int unsigned c);
        int val;
        case (fill)
            FILL_WIDE:    val = int'($urandom_range(0, 65535));
            FILL_NARROW:  val = int'($urandom_range(0, 4)) - 2;
            // negatives on even squares: every interior one is a minimum
            FILL_CHECKER: val = ((r + c) % 2) ? int'($urandom_range(0, 32767))
                                              : -int'($urandom_range(1, 32768));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       val = -32768;
                    1:       val = 32767;
                    2:       val = 0;
                    default: val = -1;
                endcase
            end
        endcase
        return pix_t'(val);
    endfunction

    task send_pixel(pix_t v);
        int unsigned g;
        g = pick_gap();
        if (g > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= v;
        do @(posedge clk); while (pix_ch.ready !== 1'b1);
        sb.take_pixel(v);
    endtask

    // Pixels in raster order from the top of a fresh image
    task send_pixels(int unsigned n, fill_t fill);
        for (int unsigned k = 0; k < n; k++)
            send_pixel(make_pixel(fill, (k / sb.cols) % sb.rows, k % sb.cols));
    endtask

    task send_list(pix_t seq[$]);
        foreach (seq[i])
            send_pixel(seq[i]);
    endtask

    // Let the block drain before touching registers
    task settle();
        pix_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.set_register(idx, data);
    endtask

    task configure(bit do_rows, bit do_cols, logic [CFG_DATA_W-1:0] rdata,
                   logic [CFG_DATA_W-1:0] cdata);
        settle();
        if (do_rows)
            write_reg(REG_ROW_COUNT, rdata);
        if (do_cols)
            write_reg(REG_COL_COUNT, cdata);
        cfg_ch.valid <= 1'b0;
    endtask

    // New geometry, then one or two images; large or unlucky ones get cut short
    task random_phase();
        int unsigned shape;
        int unsigned rdata;
        int unsigned cdata;
        int unsigned full;
        int unsigned n;
        bit          do_rows;
        bit          do_cols;
        bit          cut;
        fill_t       fill;
        shape = $urandom_range(0, 99);
        if (shape < 70)
        begin
            rdata = $urandom_range(1, 8);
            cdata = $urandom_range(1, 10);
        end
        else if (shape < 85)
        begin
            rdata = $urandom_range(1, 6);
            cdata = $urandom_range(0, 2047);
        end
        else
        begin
            rdata = $urandom_range(0, 2047);
            cdata = $urandom_range(0, 2047);
        end
        do_rows = ($urandom_range(0, 3) != 0);
        do_cols = !do_rows || ($urandom_range(0, 3) != 0);
        configure(do_rows, do_cols, rdata, cdata);
        cut = 1'b0;
        repeat ($urandom_range(1, 2))
        begin
            if (!cut)
            begin
                full = sb.rows * sb.cols;
                fill = fill_t'($urandom_range(0, 3));
                calm = ($urandom_range(0, 3) == 0);
                n    = full;
                if (full > 40 || $urandom_range(0, 6) == 0)
                begin
                    n   = $urandom_range(1, (full > 24) ? 24 : full);
                    cut = (n < full);
                end
                send_pixels(n, fill);
                random_pixels += n;
            end
        end
        calm = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        pix_t seq[$];
        pix_ch.valid     = 1'b0;
        pix_ch.pixel_in  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.reg_data  = '0;
        hold_req         = 1'b0;
        calm             = 1'b0;
        random_pixels    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // geometry out of reset
        send_pixels(sb.rows * sb.cols, FILL_WIDE);

        // zero registers read as one: single-element images
        configure(1'b1, 1'b1, '0, '0);
        send_pixel(pix_t'(32767));
        send_pixel(pix_t'(-32768));

        // 3x3: most negative center under most positive frame
        configure(1'b1, 1'b1, 3, 3);
        calm = 1'b1;
        seq = '{32767, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767};
        send_list(seq);

        // 4x4: a suppressed left neighbor reads as zero; its right side ties below and is not a minimum
        configure(1'b1, 1'b1, 4, 4);
        seq = '{9, 9, 9, 9, 9, -5, -3, 9, 9, 9, -3, 9, 9, 9, 9, 9};
        send_list(seq);
        calm = 1'b0;

        // long output hold-off while input stays offered
        configure(1'b1, 1'b1, 5, 8);
        hold_req = 1'b1;
        calm     = 1'b1;
        send_pixels(sb.rows * sb.cols, FILL_CHECKER);
        calm = 1'b0;

        // widest rows: 63 clamps, then column data above six bits is ignored
        configure(1'b1, 1'b1, 3, 11'h03F);
        send_pixels(sb.rows * sb.cols, FILL_CHECKER);
        configure(1'b1, 1'b1, 2, 11'h7E0);
        send_pixels(sb.rows * sb.cols, FILL_WIDE);

        // top of the tallest image, single column (row data clamps, column data masks to zero)
        configure(1'b1, 1'b1, 11'h7FF, 11'h040);
        send_pixels(TALL_PIXELS, FILL_NARROW);

        while (random_pixels < RANDOM_PIXELS)
            random_phase();

        pix_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d pixels sent, %0d results checked, %0d images closed, %0d minima",
                 sb.pixels, sb.results, sb.images, sb.minima);
        $display("Summary: %0d register writes, %0d long output hold-offs, %0d mismatches",
                 sb.writes, holds_done, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
